// File: hdl/tsf_pkg.sv
// Shared types, constants and pattern lookups for the think tag stream filter.
// Used by tsf_step and think_tag_stream_filter; depends on nothing else.
package tsf_pkg;

  // ASCII codes used by the tag and marker patterns
  localparam logic [7:0] CH_LT    = 8'h3C;  // <
  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_SLASH = 8'h2F;  // /
  localparam logic [7:0] CH_LB    = 8'h5B;  // [
  localparam logic [7:0] CH_RB    = 8'h5D;  // ]
  localparam logic [7:0] CH_COLON = 8'h3A;  // :
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_K     = 8'h6B;
  localparam logic [7:0] CH_UD    = 8'h44;  // D
  localparam logic [7:0] CH_UO    = 8'h4F;  // O
  localparam logic [7:0] CH_UN    = 8'h4E;  // N
  localparam logic [7:0] CH_UE    = 8'h45;  // E

  // Pattern lengths
  localparam int OPEN_LEN  = 7;
  localparam int CLOSE_LEN = 8;
  localparam int DONE_LEN  = 7;

  // Routing mode of the filter
  typedef enum logic [2:0] {
    M_NORMAL,
    M_TAG,
    M_THINK,
    M_THINKTAG,
    M_STEP
  } mode_t;

  // What one step of the compare unit does with the current byte
  typedef enum logic [1:0] {
    ACT_HOLD,   // keep byte in the hold area
    ACT_EMIT1,  // emit the head byte and drop it (pass or failed match)
    ACT_DROP,   // discard all held bytes including this one
    ACT_SPILL   // emit all held bytes including this one
  } act_t;

  typedef struct packed {
    act_t  act;
    mode_t mode_next;
    logic  think;
    logic  open_ok;
    logic  close_ok;
    logic  last_rb;
  } step_t;

  // "<think>"
  function automatic logic [7:0] open_at(input logic [2:0] i);
    logic [7:0] ch;
    unique case (i)
      3'd0:    ch = CH_LT;
      3'd1:    ch = CH_T;
      3'd2:    ch = CH_H;
      3'd3:    ch = CH_I;
      3'd4:    ch = CH_N;
      3'd5:    ch = CH_K;
      3'd6:    ch = CH_GT;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "</think>"
  function automatic logic [7:0] close_at(input logic [2:0] i);
    logic [7:0] ch;
    unique case (i)
      3'd0:    ch = CH_LT;
      3'd1:    ch = CH_SLASH;
      3'd2:    ch = CH_T;
      3'd3:    ch = CH_H;
      3'd4:    ch = CH_I;
      3'd5:    ch = CH_N;
      3'd6:    ch = CH_K;
      default: ch = CH_GT;
    endcase
    return ch;
  endfunction

  // "[[DONE:"
  function automatic logic [7:0] done_at(input logic [2:0] i);
    logic [7:0] ch;
    unique case (i)
      3'd0:    ch = CH_LB;
      3'd1:    ch = CH_LB;
      3'd2:    ch = CH_UD;
      3'd3:    ch = CH_UO;
      3'd4:    ch = CH_UN;
      3'd5:    ch = CH_UE;
      3'd6:    ch = CH_COLON;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: hdl/tsf_if.sv
// Valid/ready channel interfaces for the think tag stream filter.
// Input channel carries command and text byte; output carries routed bytes.
interface tsf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;

  modport source (output valid, output cmd, output in_byte, input ready);
  modport sink (input valid, input cmd, input in_byte, output ready);
endinterface

interface tsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       to_think;
  logic       last;

  modport source (output valid, output out_byte, output to_think, output last, input ready);
  modport sink (input valid, input out_byte, input to_think, input last, output ready);
endinterface

// File: hdl/tsf_step.sv
// Shared compare unit: decides what to do with one byte given mode and hold depth.
// Depends on tsf_pkg for modes, actions and pattern lookups.
module tsf_step #(
  parameter int MARK_MAX = 20,
  localparam int CW = $clog2(MARK_MAX + 2)
) (
  input  tsf_pkg::mode_t  mode,
  input  logic [7:0]      c,
  input  logic [CW-1:0]   h,
  input  logic            open_ok,
  input  logic            close_ok,
  input  logic            last_rb,
  output tsf_pkg::step_t  step
);
  import tsf_pkg::*;

  logic       lt_open;
  logic       lt_close;
  logic       lt_done;
  logic [2:0] h3;
  logic       o_match;
  logic       c_match;
  logic       rb;

  always_comb begin
    lt_open  = (h < CW'(OPEN_LEN));
    lt_close = (h < CW'(CLOSE_LEN));
    lt_done  = (h < CW'(DONE_LEN));
    h3       = h[2:0];
    o_match  = open_ok && lt_open && (c == open_at(h3));
    c_match  = lt_close && (c == close_at(h3));
    rb       = (c == CH_RB);

    // default: hold the byte and keep flags
    step.act       = ACT_HOLD;
    step.mode_next = mode;
    step.think     = 1'b0;
    step.open_ok   = open_ok;
    step.close_ok  = close_ok;
    step.last_rb   = last_rb;

    unique case (mode)
      M_NORMAL: begin
        if (c == CH_LT) begin
          step.mode_next = M_TAG;
          step.open_ok   = 1'b1;
          step.close_ok  = 1'b1;
        end else if (c == CH_LB) begin
          step.mode_next = M_STEP;
          step.last_rb   = 1'b0;
        end else begin
          step.act = ACT_EMIT1;
        end
      end
      M_THINK: begin
        if (c == CH_LT) begin
          step.mode_next = M_THINKTAG;
        end else begin
          step.act   = ACT_EMIT1;
          step.think = 1'b1;
        end
      end
      M_TAG: begin
        // open tag complete, stray close tag complete, both dead, or keep going
        priority if (h == CW'(OPEN_LEN - 1) && o_match) begin
          step.act       = ACT_DROP;
          step.mode_next = M_THINK;
        end else if (h == CW'(CLOSE_LEN - 1) && close_ok && c_match) begin
          step.act       = ACT_SPILL;
          step.mode_next = M_NORMAL;
        end else if (!o_match && !(close_ok && c_match)) begin
          step.act       = ACT_EMIT1;
          step.mode_next = M_NORMAL;
        end else begin
          step.open_ok  = o_match;
          step.close_ok = close_ok && c_match;
        end
      end
      M_THINKTAG: begin
        priority if (h == CW'(CLOSE_LEN - 1) && c_match) begin
          step.act       = ACT_DROP;
          step.mode_next = M_NORMAL;
        end else if (!c_match) begin
          step.act       = ACT_EMIT1;
          step.think     = 1'b1;
          step.mode_next = M_THINK;
        end else begin
          step.mode_next = M_THINKTAG;
        end
      end
      M_STEP: begin
        // closing brackets end the marker; too long or bad prefix fails it
        priority if (last_rb && rb) begin
          step.act       = ACT_DROP;
          step.mode_next = M_NORMAL;
        end else if (h >= CW'(MARK_MAX)) begin
          step.act       = ACT_EMIT1;
          step.mode_next = M_NORMAL;
        end else if (lt_done && (c != done_at(h3))) begin
          step.act       = ACT_EMIT1;
          step.mode_next = M_NORMAL;
        end else begin
          step.last_rb = rb;
        end
      end
      default: begin
        step.act       = ACT_EMIT1;
        step.mode_next = M_NORMAL;
      end
    endcase
  end

endmodule

// File: hdl/think_tag_stream_filter.sv
// Top level of the think tag stream filter: hold line, sequencer, output stage.
// Depends on tsf_pkg, tsf_if (tsf_in_if, tsf_out_if) and tsf_step.
//
//  channel  | dir | beat payload                    | notes
//  ---------+-----+---------------------------------+----------------------------
//  rx       | in  | cmd, in_byte                    | cmd 1 = flush end of stream
//  tx       | out | out_byte, to_think, last        | last marks an item's final beat
//  cfg      | in  | cfg_we, cfg_wdata (think_enable)| write only while idle
//
// A text byte is accepted and then passes through the shared compare unit.
// Each held byte replayed after a failed match takes another pass through it;
// each byte of a stray close tag spilled to main, and each held byte dropped
// while replayed bytes still wait behind it, is shifted out in the drain state.
// A flush drains its held bytes the same way, or discards them when dropped.
// A stalled tx pauses the sequencer only when it has a beat to emit, and holds
// rx off while a pending beat waits for the output register.
// Reset is synchronous; there is no clearing pass.
module think_tag_stream_filter #(
  parameter int MARK_MAX = 20
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  tsf_in_if.sink          rx,
  tsf_out_if.source       tx
);
  import tsf_pkg::*;

  localparam int D  = MARK_MAX + 1;
  localparam int IW = $clog2(D);
  localparam int CW = $clog2(D + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t        state;
  mode_t         mode;
  logic [CW-1:0] h;
  logic [CW-1:0] n;
  logic [CW-1:0] k;
  logic          open_ok;
  logic          close_ok;
  logic          last_rb;
  logic          drain_emit;
  logic          drain_think;
  logic          think_en;
  logic          pend_v;
  logic [7:0]    pend_byte;
  logic          pend_think;
  logic          o_valid;
  logic [7:0]    o_byte;
  logic          o_think;
  logic          o_last;
  logic [7:0]    hold_buf [D];

  logic [7:0]    c;
  logic [7:0]    head;
  logic [CW-1:0] hn;
  step_t         step;
  logic          out_free;
  logic          can_emit;
  logic          want_emit;
  logic          run_go;
  logic          drain_go;
  logic          emit_now;
  logic          emit_think;
  logic          shift_now;
  logic          flush_pend;
  logic          push_out;
  logic          accept;
  logic          in_think;

  tsf_step #(.MARK_MAX(MARK_MAX)) u_step (
    .mode     (mode),
    .c        (c),
    .h        (h),
    .open_ok  (open_ok),
    .close_ok (close_ok),
    .last_rb  (last_rb),
    .step     (step)
  );

  // Handshake and emit control
  always_comb begin
    c          = hold_buf[h[IW-1:0]];
    head       = hold_buf[0];
    hn         = h + CW'(1);
    in_think   = (mode == M_THINK) || (mode == M_THINKTAG);
    out_free   = !o_valid || tx.ready;
    can_emit   = !pend_v || out_free;
    want_emit  = (step.act == ACT_EMIT1) && !(step.think && !think_en);
    run_go     = !want_emit || can_emit;
    drain_go   = !drain_emit || can_emit;
    emit_now   = ((state == S_RUN) && want_emit && run_go) ||
                 ((state == S_DRAIN) && drain_emit && drain_go);
    emit_think = (state == S_RUN) ? step.think : drain_think;
    shift_now  = ((state == S_RUN) && run_go && (step.act == ACT_EMIT1)) ||
                 ((state == S_DRAIN) && drain_go);
    flush_pend = (state == S_IDLE) && pend_v && out_free;
    push_out   = (emit_now && pend_v) || flush_pend;
    rx.ready   = (state == S_IDLE) && (!pend_v || out_free);
    accept     = rx.valid && rx.ready;
  end

  assign tx.valid    = o_valid;
  assign tx.out_byte = o_byte;
  assign tx.to_think = o_think;
  assign tx.last     = o_last;

  // Hold line: append the new byte, advance by one on each emit or drop
  always_ff @(posedge clk) begin
    if (accept && !rx.cmd) begin
      hold_buf[n[IW-1:0]] <= rx.in_byte;
    end else if (shift_now) begin
      for (int i = 0; i < D - 1; i++) begin
        hold_buf[i] <= hold_buf[i + 1];
      end
    end
  end

  // Sequencer, emit stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode        <= M_NORMAL;
      h           <= '0;
      n           <= '0;
      k           <= '0;
      open_ok     <= 1'b0;
      close_ok    <= 1'b0;
      last_rb     <= 1'b0;
      drain_emit  <= 1'b0;
      drain_think <= 1'b0;
      think_en    <= 1'b0;
      pend_v      <= 1'b0;
      o_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        think_en <= cfg_wdata;
      end

      // output register: take the pending beat, or clear once taken
      if (push_out) begin
        o_valid <= 1'b1;
        o_byte  <= pend_byte;
        o_think <= pend_think;
        o_last  <= flush_pend;
      end else if (tx.ready) begin
        o_valid <= 1'b0;
      end

      // pending beat: hold the newest emit until we know if it is the last
      if (emit_now) begin
        pend_v     <= 1'b1;
        pend_byte  <= head;
        pend_think <= emit_think;
      end else if (flush_pend) begin
        pend_v <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!rx.cmd) begin
              n     <= n + CW'(1);
              state <= S_RUN;
            end else begin
              mode <= M_NORMAL;
              h    <= '0;
              if (h != '0) begin
                if (in_think && !think_en) begin
                  n <= '0;
                end else begin
                  k           <= h;
                  drain_emit  <= 1'b1;
                  drain_think <= in_think;
                  state       <= S_DRAIN;
                end
              end
            end
          end
        end
        S_RUN: begin
          if (run_go) begin
            mode <= step.mode_next;
            unique case (step.act)
              ACT_HOLD: begin
                h        <= hn;
                open_ok  <= step.open_ok;
                close_ok <= step.close_ok;
                last_rb  <= step.last_rb;
                if (hn == n) begin
                  state <= S_IDLE;
                end
              end
              ACT_EMIT1: begin
                h <= '0;
                n <= n - CW'(1);
                if (n == CW'(1)) begin
                  state <= S_IDLE;
                end
              end
              ACT_DROP: begin
                h <= '0;
                if (hn == n) begin
                  n     <= '0;
                  state <= S_IDLE;
                end else begin
                  k          <= hn;
                  drain_emit <= 1'b0;
                  state      <= S_DRAIN;
                end
              end
              ACT_SPILL: begin
                h           <= '0;
                k           <= hn;
                drain_emit  <= 1'b1;
                drain_think <= 1'b0;
                state       <= S_DRAIN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DRAIN: begin
          if (drain_go) begin
            n <= n - CW'(1);
            k <= k - CW'(1);
            if (k == CW'(1)) begin
              state <= (n == CW'(1)) ? S_IDLE : S_RUN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold depth never passes the fill of the hold line, nor the line its depth
  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    (h <= n) && (n <= CW'(D)))
    else $error("hold depth exceeds hold line fill");

  // Plain text and think modes hold nothing
  a_no_hold_plain: assert property (@(posedge clk) disable iff (rst)
    (mode == M_NORMAL || mode == M_THINK) |-> (h == '0))
    else $error("bytes held outside a tag or marker match");

  // An accepted text byte always goes to the compare unit next
  a_text_runs: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready && !rx.cmd) |=> (state == S_RUN))
    else $error("accepted text byte not processed");

endmodule
